// File: rtl/grl_pkg.sv
`timescale 1ns / 1ps
package grl_pkg;

  localparam int unsigned CELL_W = 10;
  localparam int unsigned CNT_W  = 11;
  localparam int unsigned ID_W   = 16;
  localparam logic [ID_W-1:0] ID_MAX = 16'hFFFF;

  localparam logic [1:0] MODE_CLEAR = 2'd0;
  localparam logic [1:0] MODE_LINK  = 2'd1;
  localparam logic [1:0] MODE_FLOOD = 2'd2;
  localparam logic [1:0] MODE_QUERY = 2'd3;

  localparam logic [1:0] STAT_OK    = 2'd0;
  localparam logic [1:0] STAT_RANGE = 2'd1;
  localparam logic [1:0] STAT_FULL  = 2'd2;

  typedef struct packed {
    logic [1:0]        mode;
    logic [CELL_W-1:0] cell_a;
    logic [CELL_W-1:0] cell_b;
  } in_item_t;

  typedef struct packed {
    logic [1:0]       status;
    logic [CNT_W-1:0] region_count;
    logic             connected;
  } out_item_t;

  typedef enum logic [4:0] {
    OP_NONE,
    OP_TAKE,
    OP_CLR_STEP,
    OP_BAD,
    OP_ADD_READ,
    OP_ADD_WRITE,
    OP_Q_READ_A,
    OP_Q_READ_B,
    OP_Q_DONE,
    OP_SEED_READ,
    OP_SEED_SKIP,
    OP_SEED_NEW,
    OP_FLOOD_END,
    OP_WALK_END,
    OP_POP,
    OP_CUR,
    OP_LCNT,
    OP_LINK_READ,
    OP_TGT_SKIP,
    OP_TGT_READ,
    OP_TLAB
  } dp_op_e;

  typedef enum logic [4:0] {
    ST_INIT,
    ST_IDLE,
    ST_CLR_ALL,
    ST_CLR_LAB,
    ST_ADD,
    ST_ADD_WR,
    ST_QRY,
    ST_QRY_B,
    ST_QRY_C,
    ST_SEED,
    ST_SEED_CHK,
    ST_POP,
    ST_CUR,
    ST_LCNT,
    ST_LINK,
    ST_TGT,
    ST_TLAB,
    ST_RESP
  } ctrl_state_e;

  typedef struct packed {
    dp_op_e op;
    logic   clr_cnt;
    logic   load_out;
  } dp_cmd_t;

  typedef struct packed {
    logic bad_idx;
    logic clr_done;
    logic seed_end;
    logic label_nz;
    logic depth_zero;
    logic slot_end;
    logic tgt_bad;
    logic out_busy;
  } dp_sts_t;

endpackage

// File: rtl/grl_dp.sv
`timescale 1ns / 1ps
module grl_dp #(
  parameter int unsigned NUM_CELLS = 1024,
  parameter int unsigned MAX_LINKS = 8
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [10:0]         cfg_data_i,
  input  grl_pkg::in_item_t   in_data_i,
  input  logic                out_stall_i,
  output logic                out_valid_o,
  output grl_pkg::out_item_t  out_data_o,
  input  grl_pkg::dp_cmd_t    cmd_i,
  output grl_pkg::dp_sts_t    sts_o
);
  import grl_pkg::*;

  localparam int unsigned CW = $clog2(NUM_CELLS);
  localparam int unsigned DW = CW + 1;
  localparam int unsigned LW = $clog2(MAX_LINKS + 1);
  localparam int unsigned TDEPTH = NUM_CELLS * MAX_LINKS;
  localparam int unsigned TW = (TDEPTH > 1) ? $clog2(TDEPTH) : 1;
  localparam logic [CNT_W-1:0] N_RST = (NUM_CELLS < 1024) ? CNT_W'(NUM_CELLS) : CNT_W'(1024);
  localparam logic [DW-1:0] CLR_END = DW'(NUM_CELLS);

  logic [LW-1:0]     cnt_mem [NUM_CELLS];
  logic [CELL_W-1:0] tgt_mem [TDEPTH];
  logic [ID_W-1:0]   lab_mem [NUM_CELLS];
  logic [CW-1:0]     stk_mem [NUM_CELLS];

  logic              cnt_we, cnt_re, tgt_we, tgt_re, lab_we, lab_re, stk_we, stk_re;
  logic [CW-1:0]     cnt_wa, cnt_ra, lab_wa, lab_ra, stk_wa, stk_ra;
  logic [TW-1:0]     tgt_wa, tgt_ra;
  logic [LW-1:0]     cnt_wd, cnt_rd_q;
  logic [CELL_W-1:0] tgt_wd, tgt_rd_q;
  logic [ID_W-1:0]   lab_wd, lab_rd_q;
  logic [CW-1:0]     stk_wd, stk_rd_q;

  logic [CNT_W-1:0]  n_q, n_d, seed_q, seed_d;
  logic [CELL_W-1:0] a_q, a_d, b_q, b_d;
  logic [DW-1:0]     clr_q, clr_d, depth_q, depth_d;
  logic [ID_W-1:0]   next_id_q, next_id_d, id_q, id_d, lab_a_q, lab_a_d;
  logic [CW-1:0]     cur_q, cur_d;
  logic [LW-1:0]     slot_q, slot_d, links_q, links_d;
  logic [1:0]        stat_q, stat_d;
  logic [CNT_W-1:0]  reg_q, reg_d;
  logic              conn_q, conn_d;
  logic              out_vld_q, out_vld_d;
  out_item_t         out_q, out_d;

  assign sts_o.bad_idx    = ({1'b0, a_q} >= n_q) || ({1'b0, b_q} >= n_q);
  assign sts_o.clr_done   = (clr_q == CLR_END);
  assign sts_o.seed_end   = (seed_q == n_q);
  assign sts_o.label_nz   = (lab_rd_q != '0);
  assign sts_o.depth_zero = (depth_q == '0);
  assign sts_o.slot_end   = (slot_q == links_q);
  assign sts_o.tgt_bad    = ({1'b0, tgt_rd_q} >= n_q);
  assign sts_o.out_busy   = out_vld_q && out_stall_i;

  assign out_valid_o = out_vld_q;
  assign out_data_o  = out_q;

  always_comb begin
    n_d = n_q;
    if (cfg_we_i) begin
      n_d = (32'(cfg_data_i) < 32'(NUM_CELLS)) ? cfg_data_i : CNT_W'(NUM_CELLS);
    end
    seed_d = seed_q; a_d = a_q; b_d = b_q; clr_d = clr_q; depth_d = depth_q;
    next_id_d = next_id_q; id_d = id_q; lab_a_d = lab_a_q; cur_d = cur_q;
    slot_d = slot_q; links_d = links_q; stat_d = stat_q; reg_d = reg_q; conn_d = conn_q;
    cnt_we = 1'b0; cnt_re = 1'b0; cnt_wa = '0; cnt_ra = '0; cnt_wd = '0;
    tgt_we = 1'b0; tgt_re = 1'b0; tgt_wa = '0; tgt_ra = '0; tgt_wd = '0;
    lab_we = 1'b0; lab_re = 1'b0; lab_wa = '0; lab_ra = '0; lab_wd = '0;
    stk_we = 1'b0; stk_re = 1'b0; stk_wa = '0; stk_ra = '0; stk_wd = '0;
    case (cmd_i.op)
      OP_TAKE: begin
        a_d = in_data_i.cell_a;
        b_d = in_data_i.cell_b;
        clr_d = '0;
        seed_d = '0;
        next_id_d = ID_W'(1);
        stat_d = STAT_OK;
        reg_d = '0;
        conn_d = 1'b0;
      end
      OP_CLR_STEP: begin
        lab_we = 1'b1;
        lab_wa = CW'(clr_q);
        cnt_we = cmd_i.clr_cnt;
        cnt_wa = CW'(clr_q);
        clr_d = clr_q + 1'b1;
      end
      OP_BAD: stat_d = STAT_RANGE;
      OP_ADD_READ: begin
        cnt_re = 1'b1;
        cnt_ra = CW'(a_q);
      end
      OP_ADD_WRITE: begin
        if (cnt_rd_q >= LW'(MAX_LINKS)) begin
          stat_d = STAT_FULL;
        end else begin
          tgt_we = 1'b1;
          tgt_wa = TW'(CW'(a_q)) * TW'(MAX_LINKS) + TW'(cnt_rd_q);
          tgt_wd = b_q;
          cnt_we = 1'b1;
          cnt_wa = CW'(a_q);
          cnt_wd = cnt_rd_q + 1'b1;
        end
      end
      OP_Q_READ_A: begin
        lab_re = 1'b1;
        lab_ra = CW'(a_q);
      end
      OP_Q_READ_B: begin
        lab_re = 1'b1;
        lab_ra = CW'(b_q);
        lab_a_d = lab_rd_q;
      end
      OP_Q_DONE: conn_d = (lab_a_q != '0) && (lab_rd_q != '0) && (lab_a_q == lab_rd_q);
      OP_SEED_READ: begin
        lab_re = 1'b1;
        lab_ra = CW'(seed_q);
      end
      OP_SEED_SKIP: seed_d = seed_q + 1'b1;
      OP_SEED_NEW: begin
        id_d = next_id_q;
        next_id_d = next_id_q + 1'b1;
        lab_we = 1'b1;
        lab_wa = CW'(seed_q);
        lab_wd = next_id_q;
        stk_we = 1'b1;
        stk_wa = '0;
        stk_wd = CW'(seed_q);
        depth_d = DW'(1);
      end
      OP_WALK_END: begin
        if (next_id_q == '0) next_id_d = ID_MAX;
        seed_d = seed_q + 1'b1;
      end
      OP_FLOOD_END: reg_d = CNT_W'(next_id_q - 1'b1);
      OP_POP: begin
        depth_d = depth_q - 1'b1;
        stk_re = 1'b1;
        stk_ra = CW'(depth_q - 1'b1);
      end
      OP_CUR: begin
        cur_d = stk_rd_q;
        cnt_re = 1'b1;
        cnt_ra = stk_rd_q;
        slot_d = '0;
      end
      OP_LCNT: links_d = cnt_rd_q;
      OP_LINK_READ: begin
        tgt_re = 1'b1;
        tgt_ra = TW'(cur_q) * TW'(MAX_LINKS) + TW'(slot_q);
      end
      OP_TGT_SKIP: slot_d = slot_q + 1'b1;
      OP_TGT_READ: begin
        lab_re = 1'b1;
        lab_ra = CW'(tgt_rd_q);
      end
      OP_TLAB: begin
        slot_d = slot_q + 1'b1;
        if (lab_rd_q == '0) begin
          lab_we = 1'b1;
          lab_wa = CW'(tgt_rd_q);
          lab_wd = id_q;
          if (depth_q < CLR_END) begin
            stk_we = 1'b1;
            stk_wa = CW'(depth_q);
            stk_wd = CW'(tgt_rd_q);
            depth_d = depth_q + 1'b1;
          end
        end
      end
      default: ;
    endcase
    out_vld_d = out_vld_q && out_stall_i;
    out_d = out_q;
    if (cmd_i.load_out) begin
      out_vld_d = 1'b1;
      out_d.status = stat_q;
      out_d.region_count = reg_q;
      out_d.connected = conn_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      n_q <= N_RST;
      clr_q <= '0;
      seed_q <= '0;
      depth_q <= '0;
      next_id_q <= ID_W'(1);
      out_vld_q <= 1'b0;
    end else begin
      n_q <= n_d;
      clr_q <= clr_d;
      seed_q <= seed_d;
      depth_q <= depth_d;
      next_id_q <= next_id_d;
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    a_q <= a_d; b_q <= b_d; id_q <= id_d; lab_a_q <= lab_a_d; cur_q <= cur_d;
    slot_q <= slot_d; links_q <= links_d; stat_q <= stat_d; reg_q <= reg_d;
    conn_q <= conn_d; out_q <= out_d;
  end

  always_ff @(posedge clk_i) begin
    if (cnt_we) cnt_mem[cnt_wa] <= cnt_wd;
    if (cnt_re) cnt_rd_q <= cnt_mem[cnt_ra];
  end

  always_ff @(posedge clk_i) begin
    if (tgt_we) tgt_mem[tgt_wa] <= tgt_wd;
    if (tgt_re) tgt_rd_q <= tgt_mem[tgt_ra];
  end

  always_ff @(posedge clk_i) begin
    if (lab_we) lab_mem[lab_wa] <= lab_wd;
    if (lab_re) lab_rd_q <= lab_mem[lab_ra];
  end

  always_ff @(posedge clk_i) begin
    if (stk_we) stk_mem[stk_wa] <= stk_wd;
    if (stk_re) stk_rd_q <= stk_mem[stk_ra];
  end

  a_depth_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    depth_q <= CLR_END) else $error("walk stack depth beyond cell count");
  a_clr_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    clr_q <= CLR_END) else $error("clear sweep ran past the end");
  a_seed_id: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.op == OP_SEED_NEW) |-> (next_id_q != '0)) else $error("region id zero at seed");
  a_out_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.load_out |-> !(out_vld_q && out_stall_i)) else $error("result loaded over a held beat");

endmodule

// File: rtl/grl_ctrl.sv
`timescale 1ns / 1ps
module grl_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  input  logic [1:0]       in_mode_i,
  output logic             in_stall_o,
  output grl_pkg::dp_cmd_t cmd_o,
  input  grl_pkg::dp_sts_t sts_i
);
  import grl_pkg::*;

  ctrl_state_e state_q, state_d;

  assign in_stall_o = (state_q != ST_IDLE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) state_q <= ST_INIT;
    else         state_q <= state_d;
  end

  always_comb begin
    state_d = state_q;
    cmd_o.op = OP_NONE;
    cmd_o.clr_cnt = 1'b0;
    cmd_o.load_out = 1'b0;
    case (state_q)
      ST_INIT: begin
        cmd_o.clr_cnt = 1'b1;
        if (sts_i.clr_done) state_d = ST_IDLE;
        else cmd_o.op = OP_CLR_STEP;
      end
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.op = OP_TAKE;
          case (in_mode_i)
            MODE_CLEAR: state_d = ST_CLR_ALL;
            MODE_LINK:  state_d = ST_ADD;
            MODE_FLOOD: state_d = ST_CLR_LAB;
            MODE_QUERY: state_d = ST_QRY;
            default:    state_d = ST_IDLE;
          endcase
        end
      end
      ST_CLR_ALL: begin
        cmd_o.clr_cnt = 1'b1;
        if (sts_i.clr_done) state_d = ST_RESP;
        else cmd_o.op = OP_CLR_STEP;
      end
      ST_CLR_LAB: begin
        if (sts_i.clr_done) state_d = ST_SEED;
        else cmd_o.op = OP_CLR_STEP;
      end
      ST_ADD: begin
        if (sts_i.bad_idx) begin
          cmd_o.op = OP_BAD;
          state_d = ST_RESP;
        end else begin
          cmd_o.op = OP_ADD_READ;
          state_d = ST_ADD_WR;
        end
      end
      ST_ADD_WR: begin
        cmd_o.op = OP_ADD_WRITE;
        state_d = ST_RESP;
      end
      ST_QRY: begin
        if (sts_i.bad_idx) begin
          cmd_o.op = OP_BAD;
          state_d = ST_RESP;
        end else begin
          cmd_o.op = OP_Q_READ_A;
          state_d = ST_QRY_B;
        end
      end
      ST_QRY_B: begin
        cmd_o.op = OP_Q_READ_B;
        state_d = ST_QRY_C;
      end
      ST_QRY_C: begin
        cmd_o.op = OP_Q_DONE;
        state_d = ST_RESP;
      end
      ST_SEED: begin
        if (sts_i.seed_end) begin
          cmd_o.op = OP_FLOOD_END;
          state_d = ST_RESP;
        end else begin
          cmd_o.op = OP_SEED_READ;
          state_d = ST_SEED_CHK;
        end
      end
      ST_SEED_CHK: begin
        if (sts_i.label_nz) begin
          cmd_o.op = OP_SEED_SKIP;
          state_d = ST_SEED;
        end else begin
          cmd_o.op = OP_SEED_NEW;
          state_d = ST_POP;
        end
      end
      ST_POP: begin
        if (sts_i.depth_zero) begin
          cmd_o.op = OP_WALK_END;
          state_d = ST_SEED;
        end else begin
          cmd_o.op = OP_POP;
          state_d = ST_CUR;
        end
      end
      ST_CUR: begin
        cmd_o.op = OP_CUR;
        state_d = ST_LCNT;
      end
      ST_LCNT: begin
        cmd_o.op = OP_LCNT;
        state_d = ST_LINK;
      end
      ST_LINK: begin
        if (sts_i.slot_end) begin
          state_d = ST_POP;
        end else begin
          cmd_o.op = OP_LINK_READ;
          state_d = ST_TGT;
        end
      end
      ST_TGT: begin
        // drop targets left stale by a lowered cell count
        if (sts_i.tgt_bad) begin
          cmd_o.op = OP_TGT_SKIP;
          state_d = ST_LINK;
        end else begin
          cmd_o.op = OP_TGT_READ;
          state_d = ST_TLAB;
        end
      end
      ST_TLAB: begin
        cmd_o.op = OP_TLAB;
        state_d = ST_LINK;
      end
      ST_RESP: begin
        if (!sts_i.out_busy) begin
          cmd_o.load_out = 1'b1;
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

endmodule

// File: rtl/graph_region_labeler.sv
`timescale 1ns / 1ps
// Region labeller over a directed link graph held in on-chip memories with one write and
// one registered read port each (link counts, link targets, labels, walk stack). After
// reset the block sweeps the count and label memories before it takes its first beat;
// configuration writes are taken throughout. One item is worked at a time and each gives
// one result beat. A clear sweeps the count and label memories. A flood first sweeps the
// labels, then reads the label of each seed cell, opens a walk on each unlabelled one,
// pops the walk stack, follows each stored link and closes each walk; every step waits
// on one registered read of one memory port.
module graph_region_labeler #(
  parameter int unsigned NUM_CELLS = 1024,
  parameter int unsigned MAX_LINKS = 8
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [10:0]        cfg_data_i,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  grl_pkg::in_item_t  in_data_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output grl_pkg::out_item_t out_data_o
);
  import grl_pkg::*;

  dp_cmd_t cmd;
  dp_sts_t sts;

  grl_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_mode_i  (in_data_i.mode),
    .in_stall_o (in_stall_o),
    .cmd_o      (cmd),
    .sts_i      (sts)
  );

  grl_dp #(
    .NUM_CELLS (NUM_CELLS),
    .MAX_LINKS (MAX_LINKS)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_data_i  (cfg_data_i),
    .in_data_i   (in_data_i),
    .out_stall_i (out_stall_i),
    .out_valid_o (out_valid_o),
    .out_data_o  (out_data_o),
    .cmd_i       (cmd),
    .sts_o       (sts)
  );

endmodule
